>>> design/kdpc_pkg.sv
package kdpc_pkg;

  // Number of keys scanned per tick
  localparam int unsigned KEYS = 2;

  // Held-time counter
  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] HELD_MAX = {CNT_W{1'b1}};

  // Long-press threshold after reset
  localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(50);

  typedef logic [KEYS-1:0]  key_vec_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // What one lane found for its key on one tick
  typedef struct packed {
    logic down;
    logic press;
    logic release_edge;
    logic short_press;
    logic long_press;
    logic long_hold;
  } lane_flags_t;

  // One result item as held in the output register
  typedef struct packed {
    key_vec_t debounced_down;
    key_vec_t press_edges;
    key_vec_t release_edges;
    key_vec_t short_press;
    key_vec_t long_press;
    key_vec_t long_hold;
  } result_t;

endpackage

>>> design/kdpc_in_if.sv
interface kdpc_in_if;
  import kdpc_pkg::*;

  logic     valid;
  logic     ready;
  key_vec_t raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink (input valid, input raw_levels, output ready);
endinterface

>>> design/kdpc_out_if.sv
interface kdpc_out_if;
  import kdpc_pkg::*;

  logic     valid;
  logic     ready;
  key_vec_t debounced_down;
  key_vec_t press_edges;
  key_vec_t release_edges;
  key_vec_t short_press;
  key_vec_t long_press;
  key_vec_t long_hold;

  modport source (
    output valid, output debounced_down, output press_edges, output release_edges,
    output short_press, output long_press, output long_hold, input ready
  );
  modport sink (
    input valid, input debounced_down, input press_edges, input release_edges,
    input short_press, input long_press, input long_hold, output ready
  );
endinterface

>>> design/kdpc_lane.sv
module kdpc_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 sample,
  input  kdpc_pkg::cnt_t       threshold,
  output kdpc_pkg::lane_flags_t flags
);
  import kdpc_pkg::*;

  logic prev_sample;
  logic debounced;
  cnt_t held;

  logic debounced_next;
  cnt_t held_next;

  // Take the new sample only when two raw samples agree
  always_comb begin
    debounced_next = (sample == prev_sample) ? sample : debounced;
    if (!debounced_next) begin
      held_next = '0;
    end else if (held == HELD_MAX) begin
      held_next = HELD_MAX;
    end else begin
      held_next = held + cnt_t'(1);
    end
  end

  // Classify against the counter from before this tick
  always_comb begin
    flags.down         = debounced_next;
    flags.press        = !debounced && debounced_next;
    flags.release_edge = debounced && !debounced_next;
    flags.short_press  = debounced && !debounced_next && (held < threshold);
    flags.long_press   = (held == threshold);
    flags.long_hold    = (held > threshold);
  end

  // Advance key state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= 1'b0;
      debounced   <= 1'b0;
      held        <= '0;
    end else if (advance) begin
      prev_sample <= sample;
      debounced   <= debounced_next;
      held        <= held_next;
    end
  end

endmodule

>>> design/kdpc_merge.sv
module kdpc_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  kdpc_pkg::lane_flags_t lane_flags [kdpc_pkg::KEYS],
  output logic                  take_ok,
  output logic                  res_valid,
  input  logic                  res_ready,
  output kdpc_pkg::result_t     res
);
  import kdpc_pkg::*;

  result_t merged;
  result_t skid;
  logic    skid_valid;

  // Gather one bit per key into the result vectors
  always_comb begin
    for (int k = 0; k < KEYS; k++) begin
      merged.debounced_down[k] = lane_flags[k].down;
      merged.press_edges[k]    = lane_flags[k].press;
      merged.release_edges[k]  = lane_flags[k].release_edge;
      merged.short_press[k]    = lane_flags[k].short_press;
      merged.long_press[k]     = lane_flags[k].long_press;
      merged.long_hold[k]      = lane_flags[k].long_hold;
    end
  end

  // Accept while the skid stage is free
  assign take_ok = !skid_valid;

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res        <= skid;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
        if (accept) begin
          res <= merged;
        end
      end
    end else if (accept) begin
      skid       <= merged;
      skid_valid <= 1'b1;
    end
  end

endmodule

>>> design/key_debounce_press_classifier_core.sv
// Channel  | Dir | Payload                                              | Handshake
// scan     | in  | raw_levels (active low, bit per key)                 | valid/ready
// result   | out | debounced_down, press/release edges, short/long/hold | valid/ready
// cfg      | in  | cfg_wdata = long_press_ticks                         | cfg_we
//
// One scan item is taken every clock cycle while scan.ready is high; results are registered.
// Each key has its own lane (debounce flop pair and 16-bit held counter).
// Reset clears key state and sets the threshold to 50.
// A stalled result is held in the output register; one more item lands in the
// skid stage, after which scan.ready drops until the result is taken.
module key_debounce_press_classifier_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  kdpc_pkg::cnt_t    cfg_wdata,
  kdpc_in_if.sink           scan,
  kdpc_out_if.source        result
);
  import kdpc_pkg::*;

  cnt_t        threshold;
  key_vec_t    sample;
  logic        accept;
  logic        take_ok;
  lane_flags_t lane_flags [KEYS];
  result_t     res;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Invert levels so that 1 means down
  assign sample      = ~scan.raw_levels;
  assign scan.ready  = take_ok;
  assign accept      = scan.valid && take_ok;

  // One lane per key
  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    kdpc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .advance   (accept),
      .sample    (sample[k]),
      .threshold (threshold),
      .flags     (lane_flags[k])
    );
  end

  kdpc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .lane_flags (lane_flags),
    .take_ok    (take_ok),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res        (res)
  );

  assign result.debounced_down = res.debounced_down;
  assign result.press_edges    = res.press_edges;
  assign result.release_edges  = res.release_edges;
  assign result.short_press    = res.short_press;
  assign result.long_press     = res.long_press;
  assign result.long_hold      = res.long_hold;

  // Skid stage only fills behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    !scan.ready |-> result.valid)
    else $error("skid stage full without a pending result");

  // A key cannot both press and release on one tick
  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.press_edges & result.release_edges) == '0))
    else $error("press and release on the same key");

  // Short press only comes with a release, and edges agree with the state
  a_short_on_release: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (((result.short_press & ~result.release_edges) == '0) &&
                      ((result.press_edges & ~result.debounced_down) == '0) &&
                      ((result.release_edges & result.debounced_down) == '0)))
    else $error("short press or edge inconsistent with debounced state");

  // Long press and long hold exclude each other
  a_long_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.long_press & result.long_hold) == '0))
    else $error("long press and long hold on the same key");

endmodule
